/* design/bfa_pkg.sv */
package bfa_pkg;

   localparam int BitmapWords = 512;
   localparam int NumHandles  = 64;
   localparam int WordAddrW   = $clog2(BitmapWords);
   localparam int UnitW       = WordAddrW + 3;
   localparam int SlotW       = $clog2(NumHandles);

   localparam logic [2:0] StOk       = 3'd0;
   localparam logic [2:0] StZero     = 3'd1;
   localparam logic [2:0] StNoRun    = 3'd2;
   localparam logic [2:0] StNoSlot   = 3'd3;
   localparam logic [2:0] StNotFound = 3'd4;

   localparam logic CmdAlloc = 1'b0;
   localparam logic CmdFree  = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [12:0] req_size;
      logic [11:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] alloc_offset;
   } rsp_type;

endpackage

/* design/bitmap_first_fit_allocator.sv */
// Bitmap first-fit allocator over a pool of 4096 units.
// Requests arrive on the req_ channel (valid/ready) as one bfa_pkg::req_type:
// cmd 0 allocates req_size units, cmd 1 frees the run starting at free_offset.
// Each request gives one response on the rsp_ channel: a status code and,
// for a successful allocate, the start unit of the granted run.
// One request is handled at a time; req_ready is low from acceptance until
// the response transfer completes.
// An allocate scans the bitmap memory from unit 0, each unit taking a read
// state and then a check state, until a fitting run is found or the pool
// ends, then checks one table slot per cycle (up to 64), then marks the run
// one unit at a time. A free searches the table one slot per cycle, then
// clears the run one unit at a time. Each unit step is a read-modify-write
// of one 8-bit bitmap word.
// A zero-size allocate goes straight to the response with the zero status.
// After reset a clearing pass writes every bitmap word to zero, one word a
// cycle, during which no request is accepted. Slot valid bits clear at
// once. If rsp_ready is low the response holds and no new request is
// accepted.
module bitmap_first_fit_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bfa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bfa_pkg::rsp_type rsp_data
);
   import bfa_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SLOT, S_FSRCH,
      S_MARK_RD, S_MARK_WR, S_RESP
   } state_type;

   // Bitmap memory and the handle table.
   logic [7:0]           bitmap_mem [BitmapWords];
   logic [UnitW-1:0]     slot_start [NumHandles];
   logic [12:0]          slot_len   [NumHandles];
   logic [NumHandles-1:0] slot_valid_ff, slot_valid_in;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   rsp_type           rsp_ff, rsp_in;
   logic [UnitW:0]    unit_ff, unit_in;      // scan pointer, one extra bit
   logic [UnitW-1:0]  start_ff, start_in;
   logic [13:0]       run_ff, run_in;
   logic [13:0]       left_ff, left_in;
   logic [SlotW:0]    slot_ff, slot_in;
   logic [7:0]        rd_word_ff;
   logic              mark_set_ff, mark_set_in;
   logic [UnitW-1:0]  tbl_start_rd_ff;
   logic [12:0]       tbl_len_rd_ff;

   logic              mem_we;
   logic [WordAddrW-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata;
   logic              tbl_we;
   logic [SlotW-1:0]  slot_idx;
   logic [SlotW-1:0]  slot_rd_idx;
   logic              bit_used;
   logic [7:0]        bit_mask;

   assign slot_idx    = slot_ff[SlotW-1:0];
   assign slot_rd_idx = slot_in[SlotW-1:0];
   assign mem_raddr   = unit_ff[UnitW-1:3];
   assign bit_used    = rd_word_ff[unit_ff[2:0]];
   assign bit_mask    = 8'h01 << unit_ff[2:0];

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   // Memory write port and registered read.
   // The table is read at the next slot so its entry is ready in the search state.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      rd_word_ff <= bitmap_mem[mem_raddr];
      if (tbl_we) begin
         slot_start[slot_idx] <= start_ff;
         slot_len[slot_idx]   <= req_ff.req_size;
      end
      tbl_start_rd_ff <= slot_start[slot_rd_idx];
      tbl_len_rd_ff   <= slot_len[slot_rd_idx];
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      unit_in       = unit_ff;
      start_in      = start_ff;
      run_in        = run_ff;
      left_in       = left_ff;
      slot_in       = slot_ff;
      mark_set_in   = mark_set_ff;
      slot_valid_in = slot_valid_ff;
      mem_we        = 1'b0;
      mem_waddr     = unit_ff[UnitW-1:3];
      mem_wdata     = 8'h00;
      tbl_we        = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            mem_we  = 1'b1;
            unit_in = unit_ff + (UnitW+1)'(8);
            if (unit_ff[UnitW-1:3] == WordAddrW'(BitmapWords-1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               unit_in = '0;
               run_in  = '0;
               slot_in = '0;
               rsp_in  = '{status: StOk, alloc_offset: 12'd0};
               if (req_data.cmd == CmdFree) begin
                  state_in = S_FSRCH;
               end else if (req_data.req_size == 13'd0) begin
                  rsp_in.status = StZero;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            if (unit_ff[UnitW]) begin
               rsp_in.status = StNoRun;
               state_in      = S_RESP;
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            state_in = S_SCAN_RD;
            unit_in  = unit_ff + 1'b1;
            if (bit_used) begin
               run_in = '0;
            end else begin
               if (run_ff == 14'd0) begin
                  start_in = unit_ff[UnitW-1:0];
               end
               run_in = run_ff + 1'b1;
               if (run_ff + 1'b1 >= {1'b0, req_ff.req_size}) begin
                  state_in = S_SLOT;
               end
            end
         end
         S_SLOT: begin
            if (slot_ff[SlotW] || slot_ff == (SlotW+1)'(NumHandles)) begin
               rsp_in.status = StNoSlot;
               state_in      = S_RESP;
            end else if (!slot_valid_ff[slot_idx]) begin
               tbl_we                  = 1'b1;
               slot_valid_in[slot_idx] = 1'b1;
               rsp_in.alloc_offset     = 12'(start_ff);
               unit_in                 = {1'b0, start_ff};
               left_in                 = {1'b0, req_ff.req_size};
               mark_set_in             = 1'b1;
               state_in                = S_MARK_RD;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         S_FSRCH: begin
            if (slot_ff[SlotW] || slot_ff == (SlotW+1)'(NumHandles)) begin
               rsp_in.status = StNotFound;
               state_in      = S_RESP;
            end else if (slot_valid_ff[slot_idx] &&
                         tbl_start_rd_ff == UnitW'(req_ff.free_offset)) begin
               slot_valid_in[slot_idx] = 1'b0;
               unit_in                 = {1'b0, tbl_start_rd_ff};
               left_in                 = {1'b0, tbl_len_rd_ff};
               mark_set_in             = 1'b0;
               state_in                = S_MARK_RD;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         S_MARK_RD: begin
            if (left_ff == 14'd0 || unit_ff[UnitW]) begin
               state_in = S_RESP;
            end else begin
               state_in = S_MARK_WR;
            end
         end
         S_MARK_WR: begin
            mem_we    = 1'b1;
            mem_wdata = mark_set_ff ? (rd_word_ff | bit_mask) : (rd_word_ff & ~bit_mask);
            unit_in   = unit_ff + 1'b1;
            left_in   = left_ff - 1'b1;
            state_in  = S_MARK_RD;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         unit_ff       <= '0;
         slot_valid_ff <= '0;
      end else begin
         state_ff      <= state_in;
         unit_ff       <= unit_in;
         slot_valid_ff <= slot_valid_in;
      end
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      start_ff    <= start_in;
      run_ff      <= run_in;
      left_ff     <= left_in;
      slot_ff     <= slot_in;
      mark_set_ff <= mark_set_in;
   end

endmodule
